// ===== src/assert_macros.svh =====
// Shared assertion forms for the scheduler checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/mcpes_pkg.sv =====
package mcpes_pkg;

    // Command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_MIN    = 1'b1;

    localparam int MASK_W     = 16;
    localparam int INTERVAL_W = 16;
    localparam int ACTIVE_W   = 5;
    localparam int REM_W      = 16;
    localparam int OVF_W      = 17;
    localparam int FIELD_W    = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RELOAD,
        ST_DECIDE,
        ST_SUBTRACT
    } state_t;

    // Channel memory strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic cd_we;
        logic tm_we;
    } mem_ctl_t;

endpackage

// ===== src/mcpes_chan_mem.sv =====
module mcpes_chan_mem #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32,
    parameter int CH_W      = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mcpes_pkg::mem_ctl_t   ctl,
    input  logic [CH_W-1:0]       rd_addr,
    input  logic [CH_W-1:0]       wr_addr,
    input  logic [TIME_BITS-1:0]  cd_wdata,
    input  logic                  lvl_wdata,
    input  logic [TIME_BITS-1:0]  high_wdata,
    input  logic [TIME_BITS-1:0]  low_wdata,
    output logic [TIME_BITS-1:0]  cd_rdata,
    output logic                  lvl_rdata,
    output logic [TIME_BITS-1:0]  high_rdata,
    output logic [TIME_BITS-1:0]  low_rdata
);
    import mcpes_pkg::*;

    logic [TIME_BITS:0]       cd_mem [CHANNELS];
    logic [2*TIME_BITS-1:0]   tm_mem [CHANNELS];
    logic [CHANNELS-1:0]      valid_reg;
    logic [TIME_BITS:0]       cd_q_reg;
    logic [2*TIME_BITS-1:0]   tm_q_reg;
    logic                     ok_q_reg;

    // Write countdown and level, and timing pairs
    always_ff @(posedge clk)
    begin
        if (ctl.cd_we)
        begin
            cd_mem[wr_addr] <= {lvl_wdata, cd_wdata};
        end
        if (ctl.tm_we)
        begin
            tm_mem[wr_addr] <= {high_wdata, low_wdata};
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            cd_q_reg <= cd_mem[rd_addr];
            tm_q_reg <= tm_mem[rd_addr];
        end
    end

    // Mark entries written since reset; unwritten ones read a zero countdown and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok_q_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.cd_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                ok_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign cd_rdata   = ok_q_reg ? cd_q_reg[TIME_BITS-1:0] : '0;
    assign lvl_rdata  = ok_q_reg ? cd_q_reg[TIME_BITS] : 1'b0;
    assign high_rdata = tm_q_reg[2*TIME_BITS-1:TIME_BITS];
    assign low_rdata  = tm_q_reg[TIME_BITS-1:0];

endmodule

// ===== src/multi_channel_pulse_event_scheduler_unit.sv =====
// Channel    Handshake                 Fields
// command    start / busy              command, channel, high_ticks, low_ticks,
//                                      start_level, idle_mask
// result     done (one-cycle strobe)   no_pending, remainder_ticks,
//                                      overflow_count, action_mask
// config     cfg_wen, cfg_index        cfg_data
//
// Load, start and unused commands are handled in idle; the result strobes on the next cycle.
// An event holds busy through a reload pass over the n active channels, a decide state and
// a subtract pass; each pass reads each active channel and writes it back in turn.
// With nothing pending it stops after the decide state and skips the subtract pass.
// The result strobes in the first cycle with busy low; a new word may be taken then.
// Reset clears countdowns and levels through per-entry valid bits; the receiver cannot stall.
module multi_channel_pulse_event_scheduler_unit #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          command,
    input  logic [3:0]                          channel,
    input  logic [mcpes_pkg::FIELD_W-1:0]       high_ticks,
    input  logic [mcpes_pkg::FIELD_W-1:0]       low_ticks,
    input  logic                                start_level,
    input  logic [mcpes_pkg::MASK_W-1:0]        idle_mask,
    input  logic                                cfg_wen,
    input  logic                                cfg_index,
    input  logic [mcpes_pkg::INTERVAL_W-1:0]    cfg_data,
    output logic                                done,
    output logic                                no_pending,
    output logic [mcpes_pkg::REM_W-1:0]         remainder_ticks,
    output logic [mcpes_pkg::OVF_W-1:0]         overflow_count,
    output logic [mcpes_pkg::MASK_W-1:0]        action_mask
);
    import mcpes_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   rd_busy_reg, rd_busy_next;
    logic [CH_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                   found_reg, found_next;
    logic [TIME_BITS-1:0]   gap_reg, gap_next;
    logic [CHANNELS-1:0]    act_reg, act_next;
    logic [MASK_W-1:0]      move_mask_reg, move_mask_next;
    logic [ACTIVE_W-1:0]    active_reg;
    logic [INTERVAL_W-1:0]  min_reg;
    logic                   done_reg, done_next;
    logic                   no_pending_reg, no_pending_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [OVF_W-1:0]       ovf_reg, ovf_next;
    logic [CHANNELS-1:0]    action_reg, action_next;

    logic                   accept;
    logic [CNT_W-1:0]       n_live;
    logic                   issue;
    logic                   pass_end;
    logic [TIME_BITS-1:0]   min_ext;
    logic [CHANNELS-1:0]    mask_sel;
    logic                   load_ok;

    mem_ctl_t               ctl;
    logic [CH_W-1:0]        rd_addr;
    logic [CH_W-1:0]        wr_addr;
    logic [TIME_BITS-1:0]   cd_wdata;
    logic                   lvl_wdata;
    logic [TIME_BITS-1:0]   cd_rdata;
    logic                   lvl_rdata;
    logic [TIME_BITS-1:0]   high_rdata;
    logic [TIME_BITS-1:0]   low_rdata;

    logic                   due;
    logic                   unmasked;
    logic [TIME_BITS-1:0]   reload_cd;
    logic                   reload_lvl;
    logic                   reload_above;
    logic                   sub_above;
    logic [TIME_BITS-1:0]   sub_cd;

    mcpes_chan_mem #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS),
        .CH_W      (CH_W)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .cd_wdata   (cd_wdata),
        .lvl_wdata  (lvl_wdata),
        .high_wdata (high_ticks[TIME_BITS-1:0]),
        .low_wdata  (low_ticks[TIME_BITS-1:0]),
        .cd_rdata   (cd_rdata),
        .lvl_rdata  (lvl_rdata),
        .high_rdata (high_rdata),
        .low_rdata  (low_rdata)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign min_ext  = TIME_BITS'(min_reg);
    assign mask_sel = move_mask_reg[CHANNELS-1:0];
    assign load_ok  = ({1'b0, channel} < 5'(CHANNELS));

    // Clamp the active count to the channel count
    always_comb
    begin
        if (active_reg > ACTIVE_W'(CHANNELS))
        begin
            n_live = CNT_W'(CHANNELS);
        end
        else
        begin
            n_live = active_reg[CNT_W-1:0];
        end
    end

    assign issue    = (idx_reg < n_live);
    assign pass_end = !issue && !rd_busy_reg;

    // Reload arithmetic on the word read last cycle
    assign due          = (cd_rdata <= min_ext);
    assign unmasked     = !mask_sel[rd_idx_reg];
    assign reload_cd    = (due && unmasked) ? cd_rdata + (lvl_rdata ? low_rdata : high_rdata)
                                            : cd_rdata;
    assign reload_lvl   = (due && unmasked) ? !lvl_rdata : lvl_rdata;
    assign reload_above = (reload_cd > min_ext);

    // Advance arithmetic
    assign sub_above = (cd_rdata > min_ext);
    assign sub_cd    = sub_above ? cd_rdata - gap_reg : cd_rdata;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_EVENT)
                begin
                    state_next = ST_RELOAD;
                end
            end
            ST_RELOAD:
            begin
                if (pass_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = found_reg ? ST_SUBTRACT : ST_IDLE;
            end
            ST_SUBTRACT:
            begin
                if (pass_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory strobes and result words
    always_comb
    begin
        idx_next        = idx_reg;
        rd_busy_next    = 1'b0;
        rd_idx_next     = idx_reg[CH_W-1:0];
        found_next      = found_reg;
        gap_next        = gap_reg;
        act_next        = act_reg;
        move_mask_next  = move_mask_reg;
        done_next       = 1'b0;
        no_pending_next = no_pending_reg;
        rem_next        = rem_reg;
        ovf_next        = ovf_reg;
        action_next     = action_reg;
        ctl             = '0;
        rd_addr         = idx_reg[CH_W-1:0];
        wr_addr         = rd_idx_reg;
        cd_wdata        = reload_cd;
        lvl_wdata       = reload_lvl;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    gap_next   = '0;
                    if (command != CMD_EVENT)
                    begin
                        // Non-event commands answer with an all-zero word
                        done_next       = 1'b1;
                        no_pending_next = 1'b0;
                        rem_next        = '0;
                        ovf_next        = '0;
                        action_next     = '0;
                    end
                    case (command)
                        CMD_LOAD:
                        begin
                            ctl.cd_we = load_ok;
                            ctl.tm_we = load_ok;
                            wr_addr   = channel[CH_W-1:0];
                            cd_wdata  = '0;
                            lvl_wdata = start_level;
                        end
                        CMD_START:
                        begin
                            move_mask_next = idle_mask;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RELOAD:
            begin
                ctl.rd_en    = issue;
                rd_busy_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_busy_reg)
                begin
                    // Write back the reloaded channel and track the least gap
                    ctl.cd_we = 1'b1;
                    if (reload_above && (!found_reg || reload_cd < gap_reg))
                    begin
                        found_next = 1'b1;
                        gap_next   = reload_cd;
                    end
                end
            end
            ST_DECIDE:
            begin
                idx_next = '0;
                act_next = '0;
                if (!found_reg)
                begin
                    // Nothing pending: mask every channel until the next start
                    move_mask_next  = '1;
                    done_next       = 1'b1;
                    no_pending_next = 1'b1;
                    rem_next        = '0;
                    ovf_next        = '0;
                    action_next     = '0;
                end
            end
            ST_SUBTRACT:
            begin
                ctl.rd_en    = issue;
                rd_busy_next = issue;
                cd_wdata     = sub_cd;
                lvl_wdata    = lvl_rdata;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_busy_reg)
                begin
                    ctl.cd_we = 1'b1;
                    if (sub_cd <= min_ext && unmasked)
                    begin
                        act_next[rd_idx_reg] = 1'b1;
                    end
                end
                if (pass_end)
                begin
                    done_next       = 1'b1;
                    no_pending_next = 1'b0;
                    rem_next        = gap_reg[REM_W-1:0];
                    ovf_next        = OVF_W'(gap_reg[TIME_BITS-1:16]) + OVF_W'(1);
                    action_next     = act_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_busy_reg   <= 1'b0;
            move_mask_reg <= '1;
            active_reg    <= ACTIVE_W'(1);
            min_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_busy_reg   <= rd_busy_next;
            move_mask_reg <= move_mask_next;
            done_reg      <= done_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_ACTIVE: active_reg <= cfg_data[ACTIVE_W-1:0];
                    CFG_MIN:    min_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rd_idx_reg     <= rd_idx_next;
        found_reg      <= found_next;
        gap_reg        <= gap_next;
        act_reg        <= act_next;
        no_pending_reg <= no_pending_next;
        rem_reg        <= rem_next;
        ovf_reg        <= ovf_next;
        action_reg     <= action_next;
    end

    assign done            = done_reg;
    assign no_pending      = no_pending_reg;
    assign remainder_ticks = rem_reg;
    assign overflow_count  = ovf_reg;
    assign action_mask     = MASK_W'(action_reg);

endmodule

// ===== src/mcpes_checker.sv =====
`include "assert_macros.svh"

module mcpes_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [1:0]                        command,
    input logic                              done,
    input logic                              no_pending,
    input logic [mcpes_pkg::REM_W-1:0]       remainder_ticks,
    input logic [mcpes_pkg::OVF_W-1:0]       overflow_count,
    input logic [mcpes_pkg::MASK_W-1:0]      action_mask
);
    import mcpes_pkg::*;

    // A non-event command answers in the following cycle
    `ASSERT_NEXT(a_quick_answer, clk, rst_n, start && !busy && command != CMD_EVENT, done)

    // An event command occupies the block after it is taken
    `ASSERT_NEXT(a_event_busy, clk, rst_n, start && !busy && command == CMD_EVENT, busy)

    // An empty schedule reports zero fields
    `ASSERT_IMPL(a_empty_zero, clk, rst_n, done && no_pending,
                 remainder_ticks == '0 && overflow_count == '0 && action_mask == '0)

    // The overflow count never exceeds one past the top of the upper half
    `ASSERT_IMPL(a_ovf_range, clk, rst_n, done,
                 !(overflow_count[16] && overflow_count[15:0] != 16'd0))

endmodule

bind multi_channel_pulse_event_scheduler_unit mcpes_checker u_mcpes_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .done            (done),
    .no_pending      (no_pending),
    .remainder_ticks (remainder_ticks),
    .overflow_count  (overflow_count),
    .action_mask     (action_mask)
);
